// ===== hdl/assert_macros.svh =====
// assertion macros used by interval_range_table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define IRT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define IRT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/irt_pkg.sv =====
// types and constants of the interval range table
package irt_pkg;

	localparam int KEY_W    = 32;
	localparam int VAL_W    = 8;
	localparam int STATUS_W = 2;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [VAL_W-1:0]        val_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		CMD_LOOKUP = 1'b0,
		CMD_ASSIGN = 1'b1
	} cmd_t;

	// per-cycle command to every cell of the row
	typedef struct packed {
		logic probe;
		logic shl;
		logic ins;
	} irt_ctl_t;

	// what a cell shows its neighbors
	typedef struct packed {
		key_t key;
		val_t value;
		logic lt;
		logic b;
		logic g;
		logic le;
		logic inr;
	} irt_link_t;

	// stands in for the missing neighbors past either end of the row
	localparam irt_link_t LINK_EDGE = '{
		key: '0, value: '0, lt: 1'b1, b: 1'b0, g: 1'b0, le: 1'b0, inr: 1'b0
	};

endpackage

// ===== hdl/irt_req_if.sv =====
// request channel of the interval range table
interface irt_req_if import irt_pkg::*; ();
	logic valid;
	logic ready;
	logic cmd;
	key_t key_start;
	key_t key_stop;
	val_t new_value;

	modport source (output valid, output cmd, output key_start, output key_stop,
		output new_value, input ready);
	modport sink (input valid, input cmd, input key_start, input key_stop,
		input new_value, output ready);
endinterface

// ===== hdl/irt_rsp_if.sv =====
// response channel of the interval range table
interface irt_rsp_if import irt_pkg::*; ();
	logic                valid;
	logic                ready;
	val_t                read_value;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output read_value, output status, input ready);
	modport sink (input valid, input read_value, input status, output ready);
endinterface

// ===== hdl/irt_cfg_if.sv =====
// configuration write channel of the interval range table
interface irt_cfg_if import irt_pkg::*; ();
	logic valid;
	logic ready;
	val_t default_value;

	modport source (output valid, output default_value, input ready);
	modport sink (input valid, input default_value, output ready);
endinterface

// ===== hdl/irt_cell.sv =====
// one breakpoint cell of the sorted row
module irt_cell import irt_pkg::*; #(
	parameter int CNT_W = 7,
	parameter int INDEX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  irt_ctl_t         ctl,
	input  logic [CNT_W-1:0] count,
	input  key_t             start,
	input  key_t             stop,
	input  key_t             probe,
	input  val_t             new_value,
	input  val_t             old_value,
	input  irt_link_t        nxt,
	input  irt_link_t        prv1,
	input  irt_link_t        prv2,
	output irt_link_t        self,
	output logic             hit,
	output logic             pair,
	output val_t             sel_value
);

	localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

	key_t key_q;
	val_t val_q;
	logic hit_q;
	logic occ, ge, le, le_stop;
	logic lt, b, g, lep, inr;

	always_comb begin
		occ     = IDX < count;
		ge      = key_q >= start;
		le      = key_q <= probe;
		le_stop = key_q <= stop;
		lt      = occ & ~ge;
		g       = occ & ge;
		lep     = occ & le;
		inr     = g & le_stop;
		// first cell at or above start: where the new breakpoint goes
		b       = ~lt & prv1.lt;
	end

	always_ff @(posedge clk) begin
		if (ctl.shl && g) begin
			key_q <= nxt.key;
			val_q <= nxt.value;
		end else if (ctl.ins) begin
			if (b) begin
				key_q <= start;
				val_q <= new_value;
			end else if (prv1.b) begin
				key_q <= stop;
				val_q <= old_value;
			end else if (prv2.g) begin
				key_q <= prv2.key;
				val_q <= prv2.value;
			end
		end
	end

	// last entry not above the probe key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.probe) begin
			hit_q <= lep & ~nxt.le;
		end
	end

	assign self = '{key: key_q, value: val_q, lt: lt, b: b, g: g, le: lep, inr: inr};
	assign hit       = hit_q;
	assign pair      = inr & nxt.inr;
	assign sel_value = hit_q ? val_q : '0;

endmodule

// ===== hdl/interval_range_table.sv =====
// interval range table: sorted breakpoint row with lookup and interval assign
//
// channels: req (sink) carries cmd, key_start, key_stop, new_value; rsp (source)
// carries read_value and status; cfg (sink) writes default_value, always ready.
// a request is taken when req.valid and req.ready are high at a clock edge.
// one request at a time: req.ready is high only while no request is in work.
// lookup: the request steps through probe, select and resp; the response is
// registered on leaving resp, and then the next request can be taken.
// assign: the request steps through probe, select, delete, insert and resp;
// delete repeats once per breakpoint removed, the row dropping one breakpoint
// per cycle by shifting the cells at or above start one place down; insert
// then opens two places and writes both new breakpoints in the same cycle.
// empty intervals and table-full rejections go from select straight to resp
// and answer from there.
// the rsp register holds a finished response while rsp.ready is low; the next
// request is taken meanwhile and waits in its last step until rsp is free.
// reset empties the table, sets default_value to 0 and drops rsp.valid.
module interval_range_table import irt_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input logic   clk,
	input logic   arst_n,
	irt_req_if.sink   req,
	irt_rsp_if.source rsp,
	irt_cfg_if.sink   cfg
);

`include "assert_macros.svh"

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_PROBE  = 6'b000010,
		S_SELECT = 6'b000100,
		S_DELETE = 6'b001000,
		S_INSERT = 6'b010000,
		S_RESP   = 6'b100000
	} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	key_t             start_q;
	key_t             stop_q;
	val_t             newval_q;
	val_t             sel_q;
	val_t             default_q;
	logic [CNT_W-1:0] count_q;
	logic             full_q;
	logic             empty_q;
	status_t          status_q;
	logic             out_valid_q;
	val_t             out_value_q;
	status_t          out_status_q;

	irt_ctl_t  ctl;
	irt_link_t links [TABLE_DEPTH];
	logic      hit_v  [TABLE_DEPTH];
	logic      pair_v [TABLE_DEPTH];
	val_t      sel_v  [TABLE_DEPTH];
	key_t      probe;
	val_t      or_val;
	logic      any_hit, any_in, any_pair, full_d, out_free;

	assign probe = (cmd_q == CMD_ASSIGN) ? stop_q : start_q;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		irt_link_t nxt_l, prv1_l, prv2_l;

		if (i == TABLE_DEPTH - 1) begin : g_last
			assign nxt_l = LINK_EDGE;
		end else begin : g_next
			assign nxt_l = links[i+1];
		end
		if (i == 0) begin : g_first
			assign prv1_l = LINK_EDGE;
		end else begin : g_prev
			assign prv1_l = links[i-1];
		end
		if (i < 2) begin : g_low
			assign prv2_l = LINK_EDGE;
		end else begin : g_prev2
			assign prv2_l = links[i-2];
		end

		irt_cell #(
			.CNT_W (CNT_W),
			.INDEX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.count     (count_q),
			.start     (start_q),
			.stop      (stop_q),
			.probe     (probe),
			.new_value (newval_q),
			.old_value (sel_q),
			.nxt       (nxt_l),
			.prv1      (prv1_l),
			.prv2      (prv2_l),
			.self      (links[i]),
			.hit       (hit_v[i]),
			.pair      (pair_v[i]),
			.sel_value (sel_v[i])
		);
	end

	always_comb begin
		or_val   = '0;
		any_hit  = 1'b0;
		any_in   = 1'b0;
		any_pair = 1'b0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			or_val   = or_val | sel_v[i];
			any_hit  = any_hit | hit_v[i];
			any_in   = any_in | links[i].inr;
			any_pair = any_pair | pair_v[i];
		end
	end

	// the interval is contiguous, so fewer than two removals means no adjacent pair
	assign full_d = ((count_q == CNT_W'(TABLE_DEPTH)) && !any_pair) ||
		((count_q == CNT_W'(TABLE_DEPTH - 1)) && !any_in);

	always_comb begin
		ctl       = '0;
		ctl.probe = state_q == S_PROBE;
		ctl.shl   = (state_q == S_DELETE) && any_in;
		ctl.ins   = state_q == S_INSERT;
	end

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = state_q == S_IDLE;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q    <= cmd_t'(req.cmd);
			start_q  <= req.key_start;
			stop_q   <= req.key_stop;
			newval_q <= req.new_value;
		end
		if (state_q == S_PROBE) begin
			full_q  <= full_d;
			empty_q <= !(start_q < stop_q);
		end
		if (state_q == S_SELECT) begin
			sel_q <= any_hit ? or_val : default_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			default_q <= '0;
			status_q  <= ST_DONE;
		end else begin
			if (cfg.valid && cfg.ready) begin
				default_q <= cfg.default_value;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					state_q <= S_SELECT;
				end
				S_SELECT: begin
					if (cmd_q == CMD_LOOKUP) begin
						status_q <= ST_DONE;
						state_q  <= S_RESP;
					end else if (empty_q) begin
						status_q <= ST_EMPTY;
						state_q  <= S_RESP;
					end else if (full_q) begin
						status_q <= ST_FULL;
						state_q  <= S_RESP;
					end else begin
						state_q <= S_DELETE;
					end
				end
				S_DELETE: begin
					if (any_in) begin
						count_q <= count_q - CNT_W'(1);
					end else begin
						state_q <= S_INSERT;
					end
				end
				S_INSERT: begin
					count_q  <= count_q + CNT_W'(2);
					status_q <= ST_DONE;
					state_q  <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RESP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			out_value_q  <= (cmd_q == CMD_LOOKUP) ? sel_q : '0;
			out_status_q <= status_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = out_value_q;
	assign rsp.status     = out_status_q;

	`IRT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(TABLE_DEPTH), "entry count past depth")
	`IRT_ASSERT_NXT(a_req_to_probe, req.valid && req.ready, state_q == S_PROBE, "request not probed")
	`IRT_ASSERT_NXT(a_insert_two, state_q == S_INSERT, count_q == $past(count_q) + CNT_W'(2),
		"insert did not add two entries")
	`IRT_ASSERT_IMP(a_reject_no_delete, state_q == S_DELETE,
		cmd_q == CMD_ASSIGN && !empty_q && !full_q, "delete on rejected request")

endmodule
